FILE: sv/gapped_alignment_block_splitter_macros.svh
// Assertion macros shared by the checker of the gapped alignment block splitter.
// They expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GAPPED_ALIGNMENT_BLOCK_SPLITTER_MACROS_SVH
`define GAPPED_ALIGNMENT_BLOCK_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define GABS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication.
`define GABS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: sv/gabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gabs_pkg
// Widths, types and helper functions of the gapped alignment block splitter.
// ----------------------------------------------------------------------------
package gabs_pkg;

    localparam int COORD_W     = 32;
    localparam int MAX_COLUMNS = 65536;
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
    localparam int TOT_W       = CNT_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] SAT_LIMIT = CNT_W'(MAX_COLUMNS);

    typedef struct packed {
        logic [CNT_W-1:0]   block_size;
        logic [COORD_W-1:0] block_query_start;
        logic [COORD_W-1:0] block_target_start;
        logic               final_block;
        logic [CNT_W-1:0]   query_insert_runs;
        logic [CNT_W-1:0]   query_insert_bases;
        logic [CNT_W-1:0]   target_insert_runs;
        logic [CNT_W-1:0]   target_insert_bases;
        logic [TOT_W-1:0]   total_blocks;
        logic               leading_gap_error;
    } t_result;

    // All results caused by one column: an optional block and an optional flush.
    typedef struct packed {
        logic    has_blk;
        t_result blk;
        logic    has_fin;
        t_result fin;
    } t_entry;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < SAT_LIMIT) ? v + CNT_W'(1) : SAT_LIMIT;
    endfunction

    function automatic logic [CNT_W-1:0] sat_size(input logic [COORD_W-1:0] fin,
                                                  input logic [COORD_W-1:0] beg);
        logic [COORD_W-1:0] d;
        d = fin - beg;
        return (d < COORD_W'(SAT_LIMIT)) ? d[CNT_W-1:0] : SAT_LIMIT;
    endfunction

endpackage

FILE: sv/gabs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gabs_front
// Tracks gap state, coordinates and counters, and classifies each column into
// the results it causes.
// ----------------------------------------------------------------------------
module gabs_front import gabs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_first_column,
    input  logic               i_last_column,
    input  logic [COORD_W-1:0] i_query_start,
    input  logic [COORD_W-1:0] i_target_start,
    input  logic               i_query_is_gap,
    input  logic               i_target_is_gap,
    output logic               o_push,
    output t_entry             o_entry
);

    logic               r_inside, n_inside;
    logic [COORD_W-1:0] r_bq, n_bq, r_bt, n_bt, r_qe, n_qe, r_te, n_te;
    logic               r_pq, n_pq, r_pt, n_pt;
    logic [CNT_W-1:0]   r_qr, n_qr, r_qb, n_qb, r_tr, n_tr, r_tb, n_tb;
    logic               r_err, n_err;
    logic               qg, tg;

    assign qg = i_query_is_gap;
    assign tg = i_target_is_gap;

    always_comb begin
        // A first column restarts the alignment from its start coordinates.
        n_inside = r_inside;
        n_bq     = r_bq;
        n_bt     = r_bt;
        n_qe     = r_qe;
        n_te     = r_te;
        n_pq     = r_pq;
        n_pt     = r_pt;
        n_qr     = r_qr;
        n_qb     = r_qb;
        n_tr     = r_tr;
        n_tb     = r_tb;
        n_err    = r_err;
        if (i_first_column) begin
            n_inside = 1'b0;
            n_bq     = i_query_start;
            n_qe     = i_query_start;
            n_bt     = i_target_start;
            n_te     = i_target_start;
            n_pq     = 1'b0;
            n_pt     = 1'b0;
            n_qr     = '0;
            n_qb     = '0;
            n_tr     = '0;
            n_tb     = '0;
            n_err    = qg | tg;
        end

        o_entry = '0;
        if (!n_err) begin
            if (qg || tg) begin
                if (!n_inside) begin
                    o_entry.has_blk                = 1'b1;
                    o_entry.blk.block_size         = sat_size(n_qe, n_bq);
                    o_entry.blk.block_query_start  = n_bq;
                    o_entry.blk.block_target_start = n_bt;
                    n_inside                       = 1'b1;
                end else if ((qg && n_pt) || (tg && n_pq)) begin
                    // The gap switches rows: an empty block separates the runs.
                    o_entry.has_blk                = 1'b1;
                    o_entry.blk.block_query_start  = n_qe;
                    o_entry.blk.block_target_start = n_te;
                end
                if (!qg) begin
                    n_qe = n_qe + COORD_W'(1);
                end
                if (!tg) begin
                    n_te = n_te + COORD_W'(1);
                end
            end else begin
                if (n_inside) begin
                    n_bq     = n_qe;
                    n_bt     = n_te;
                    n_inside = 1'b0;
                end
                n_qe = n_qe + COORD_W'(1);
                n_te = n_te + COORD_W'(1);
            end
            if (qg) begin
                if (!n_pq) begin
                    n_qr = sat_inc(n_qr);
                end
                n_qb = sat_inc(n_qb);
            end
            if (tg) begin
                if (!n_pt) begin
                    n_tr = sat_inc(n_tr);
                end
                n_tb = sat_inc(n_tb);
            end
            n_pq = qg;
            n_pt = tg;
        end

        if (i_last_column) begin
            o_entry.has_fin         = 1'b1;
            o_entry.fin.final_block = 1'b1;
            if (n_err) begin
                o_entry.fin.leading_gap_error = 1'b1;
            end else begin
                o_entry.fin.block_size          = sat_size(n_qe, n_bq);
                o_entry.fin.block_query_start   = n_bq;
                o_entry.fin.block_target_start  = n_bt;
                o_entry.fin.query_insert_runs   = n_qr;
                o_entry.fin.query_insert_bases  = n_qb;
                o_entry.fin.target_insert_runs  = n_tr;
                o_entry.fin.target_insert_bases = n_tb;
                o_entry.fin.total_blocks        = TOT_W'(n_qr) + TOT_W'(n_tr) + TOT_W'(1);
            end
        end
    end

    assign o_push = i_accept & (o_entry.has_blk | o_entry.has_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_bq     <= '0;
            r_bt     <= '0;
            r_qe     <= '0;
            r_te     <= '0;
            r_pq     <= 1'b0;
            r_pt     <= 1'b0;
            r_qr     <= '0;
            r_qb     <= '0;
            r_tr     <= '0;
            r_tb     <= '0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            r_inside <= n_inside;
            r_bq     <= n_bq;
            r_bt     <= n_bt;
            r_qe     <= n_qe;
            r_te     <= n_te;
            r_pq     <= n_pq;
            r_pt     <= n_pt;
            r_qr     <= n_qr;
            r_qb     <= n_qb;
            r_tr     <= n_tr;
            r_tb     <= n_tb;
            r_err    <= n_err;
        end
    end

endmodule

FILE: sv/gabs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gabs_queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module gabs_queue import gabs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: sv/gabs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gabs_back
// Takes entries from the queue and delivers their results one per transfer
// through an output register.
// ----------------------------------------------------------------------------
module gabs_back import gabs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_entry  i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result r_out, r_pend;
    logic    r_out_valid, r_pend_valid;
    logic    load;

    // The output register may take a new result when empty or being drained.
    assign load     = !r_out_valid || i_ready;
    assign o_pop    = load && !r_pend_valid && !i_empty;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (load) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (!i_empty) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= i_head.has_blk & i_head.has_fin;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (!i_empty) begin
                r_out  <= i_head.has_blk ? i_head.blk : i_head.fin;
                r_pend <= i_head.fin;
            end
        end
    end

endmodule

FILE: sv/gapped_alignment_block_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapped_alignment_block_splitter
// Splits a stream of alignment columns into ungapped blocks with gap counts.
// ----------------------------------------------------------------------------
// The front takes one alignment column per clock cycle whenever the
// four-entry result queue has room, and keeps all running state. A column
// yields no result, one result, or two (a block and the final flush);
// results leave at one per transfer from an output register, so the
// sustained rate is one column per cycle for as long as results are taken
// at the rate they arise. With no backlog a result passes through the queue
// and then the output register; the back empties the queue into the output.
module gapped_alignment_block_splitter import gabs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_first_column,
    input  logic               i_last_column,
    input  logic [COORD_W-1:0] i_query_start,
    input  logic [COORD_W-1:0] i_target_start,
    input  logic               i_query_is_gap,
    input  logic               i_target_is_gap,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CNT_W-1:0]   o_block_size,
    output logic [COORD_W-1:0] o_block_query_start,
    output logic [COORD_W-1:0] o_block_target_start,
    output logic               o_final_block,
    output logic [CNT_W-1:0]   o_query_insert_runs,
    output logic [CNT_W-1:0]   o_query_insert_bases,
    output logic [CNT_W-1:0]   o_target_insert_runs,
    output logic [CNT_W-1:0]   o_target_insert_bases,
    output logic [TOT_W-1:0]   o_total_blocks,
    output logic               o_leading_gap_error
);

    logic    accept, push, pop, full, empty;
    t_entry  entry, head;
    t_result result;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    gabs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_first_column  (i_first_column),
        .i_last_column   (i_last_column),
        .i_query_start   (i_query_start),
        .i_target_start  (i_target_start),
        .i_query_is_gap  (i_query_is_gap),
        .i_target_is_gap (i_target_is_gap),
        .o_push          (push),
        .o_entry         (entry)
    );

    gabs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    gabs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_block_size          = result.block_size;
    assign o_block_query_start   = result.block_query_start;
    assign o_block_target_start  = result.block_target_start;
    assign o_final_block         = result.final_block;
    assign o_query_insert_runs   = result.query_insert_runs;
    assign o_query_insert_bases  = result.query_insert_bases;
    assign o_target_insert_runs  = result.target_insert_runs;
    assign o_target_insert_bases = result.target_insert_bases;
    assign o_total_blocks        = result.total_blocks;
    assign o_leading_gap_error   = result.leading_gap_error;

endmodule

FILE: sv/gabs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gabs_checker
// Port-level checks of the gapped alignment block splitter, bound to the top.
// ----------------------------------------------------------------------------
`include "gapped_alignment_block_splitter_macros.svh"

module gabs_checker import gabs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               i_first_column,
    input  logic               i_last_column,
    input  logic [COORD_W-1:0] i_query_start,
    input  logic [COORD_W-1:0] i_target_start,
    input  logic               i_query_is_gap,
    input  logic               i_target_is_gap,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [CNT_W-1:0]   o_block_size,
    input  logic [COORD_W-1:0] o_block_query_start,
    input  logic [COORD_W-1:0] o_block_target_start,
    input  logic               o_final_block,
    input  logic [CNT_W-1:0]   o_query_insert_runs,
    input  logic [CNT_W-1:0]   o_query_insert_bases,
    input  logic [CNT_W-1:0]   o_target_insert_runs,
    input  logic [CNT_W-1:0]   o_target_insert_bases,
    input  logic [TOT_W-1:0]   o_total_blocks,
    input  logic               o_leading_gap_error
);

    // A stalled result stays offered with its size, query start and final flag unchanged.
    `GABS_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_block_size) && $stable(o_block_query_start) && $stable(o_final_block))

    // An error result is a final result with no block in it.
    `GABS_ASSERT_IMP(a_err_final, o_out_valid && o_leading_gap_error, o_final_block && (o_block_size == '0) && (o_block_query_start == '0) && (o_total_blocks == '0))

    // Intermediate blocks carry no counts.
    `GABS_ASSERT_IMP(a_mid_clean, o_out_valid && !o_final_block, (o_total_blocks == '0) && (o_query_insert_runs == '0) && (o_target_insert_bases == '0) && !o_leading_gap_error)

    // The block count of a good flush follows from the run counts.
    `GABS_ASSERT_IMP(a_total, o_out_valid && o_final_block && !o_leading_gap_error, o_total_blocks == TOT_W'(o_query_insert_runs) + TOT_W'(o_target_insert_runs) + TOT_W'(1))

endmodule

bind gapped_alignment_block_splitter gabs_checker u_gabs_checker (.*);

FILE: dv/gapped_alignment_block_splitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapped_alignment_block_splitter_test
// Self-checking bench that streams alignment columns into the block splitter
// and checks every block and final flush against an in-bench predictor or a
// typed row. A short table of directed columns runs first. Random alignments
// follow, with idle gaps on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module gapped_alignment_block_splitter_test;
    import gabs_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_COLUMNS = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_COLUMNS  = 60;

    typedef struct packed {
        logic               first;
        logic               last;
        logic [COORD_W-1:0] q_start;
        logic [COORD_W-1:0] t_start;
        logic               q_gap;
        logic               t_gap;
    } column_t;

    typedef struct packed {
        column_t col;
        logic    typed;
        t_result want;
    } dir_row_t;

    localparam t_result NO_BLOCK    = '0;
    localparam t_result ERROR_FLUSH = '{17'd0, 32'd0, 32'd0, 1'b1, 17'd0, 17'd0,
                                        17'd0, 17'd0, 18'd0, 1'b1};

    // Rows with typed = 1 carry their expected flush; the rest go through the
    // predictor.
    localparam dir_row_t DIRECTED [22] = '{
        // A single column right after reset flushes a one-column block at zero.
        '{'{1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b1,
          '{17'd1, 32'h0000_0000, 32'h0000_0000, 1'b1, 17'd0, 17'd0, 17'd0, 17'd0,
            18'd1, 1'b0}},
        '{'{1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1,
          '{17'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 17'd0, 17'd0, 17'd0, 17'd0,
            18'd1, 1'b0}},
        '{'{1'b1, 1'b1, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1, 1'b0}, 1'b1, ERROR_FLUSH},
        // Leading target gap: the following columns are ignored until the flush.
        '{'{1'b1, 1'b0, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b1, ERROR_FLUSH},
        // Target gap, then query gap, both, and target gap again: a two-column block, then zero-size blocks.
        '{'{1'b1, 1'b0, 32'hFFFF_FFFE, 32'h0000_0010, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        // Columns after a flush without a new first column keep the running state.
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b1, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}, 1'b0, NO_BLOCK},
        '{'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_BLOCK},
        // A trailing gap on the last column gives a block and the flush together.
        '{'{1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_BLOCK},
        '{'{1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, ERROR_FLUSH}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_first_column;
    logic               i_last_column;
    logic [COORD_W-1:0] i_query_start;
    logic [COORD_W-1:0] i_target_start;
    logic               i_query_is_gap;
    logic               i_target_is_gap;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [CNT_W-1:0]   o_block_size;
    logic [COORD_W-1:0] o_block_query_start;
    logic [COORD_W-1:0] o_block_target_start;
    logic               o_final_block;
    logic [CNT_W-1:0]   o_query_insert_runs;
    logic [CNT_W-1:0]   o_query_insert_bases;
    logic [CNT_W-1:0]   o_target_insert_runs;
    logic [CNT_W-1:0]   o_target_insert_bases;
    logic [TOT_W-1:0]   o_total_blocks;
    logic               o_leading_gap_error;

    // Predictor state.
    logic               gap_open;
    logic [COORD_W-1:0] blk_q0;
    logic [COORD_W-1:0] blk_t0;
    logic [COORD_W-1:0] q_pos;
    logic [COORD_W-1:0] t_pos;
    logic               last_qg;
    logic               last_tg;
    logic [CNT_W-1:0]   q_runs;
    logic [CNT_W-1:0]   q_bases;
    logic [CNT_W-1:0]   t_runs;
    logic [CNT_W-1:0]   t_bases;
    logic               aln_error;

    t_result block_queue[$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    bit      in_calm     = 1'b0;
    bit      out_calm    = 1'b0;
    bit      hold_off_req = 1'b0;

    gapped_alignment_block_splitter DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_first_column        (i_first_column),
        .i_last_column         (i_last_column),
        .i_query_start         (i_query_start),
        .i_target_start        (i_target_start),
        .i_query_is_gap        (i_query_is_gap),
        .i_target_is_gap       (i_target_is_gap),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_block_size          (o_block_size),
        .o_block_query_start   (o_block_query_start),
        .o_block_target_start  (o_block_target_start),
        .o_final_block         (o_final_block),
        .o_query_insert_runs   (o_query_insert_runs),
        .o_query_insert_bases  (o_query_insert_bases),
        .o_target_insert_runs  (o_target_insert_runs),
        .o_target_insert_bases (o_target_insert_bases),
        .o_total_blocks        (o_total_blocks),
        .o_leading_gap_error   (o_leading_gap_error)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == SAT_LIMIT) ? v : v + 1'b1;
    endfunction

    // Distance from block start to end, clipped at the column limit.
    function automatic logic [CNT_W-1:0] clip_size(input logic [COORD_W-1:0] e,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] span;
        span = e - b;
        return (span[COORD_W-1:CNT_W-1] != '0) ? SAT_LIMIT : span[CNT_W-1:0];
    endfunction

    function automatic int split_column(input column_t c, output t_result r0,
                                        output t_result r1);
        t_result res [2];
        int      n;
        n      = 0;
        res[0] = '0;
        res[1] = '0;
        if (c.first) begin
            gap_open  = 1'b0;
            last_qg   = 1'b0;
            last_tg   = 1'b0;
            q_runs    = '0;
            q_bases   = '0;
            t_runs    = '0;
            t_bases   = '0;
            blk_q0    = c.q_start;
            q_pos     = c.q_start;
            blk_t0    = c.t_start;
            t_pos     = c.t_start;
            aln_error = c.q_gap | c.t_gap;
        end
        if (!aln_error) begin
            if (c.q_gap || c.t_gap) begin
                if (!gap_open) begin
                    res[n].block_size         = clip_size(q_pos, blk_q0);
                    res[n].block_query_start  = blk_q0;
                    res[n].block_target_start = blk_t0;
                    n++;
                    gap_open = 1'b1;
                end else if ((c.q_gap && last_tg) || (c.t_gap && last_qg)) begin
                    // A gap switching rows leaves an empty block between the runs.
                    res[n].block_query_start  = q_pos;
                    res[n].block_target_start = t_pos;
                    n++;
                end
                if (!c.q_gap) q_pos = q_pos + 1'b1;
                if (!c.t_gap) t_pos = t_pos + 1'b1;
            end else begin
                if (gap_open) begin
                    blk_q0   = q_pos;
                    blk_t0   = t_pos;
                    gap_open = 1'b0;
                end
                q_pos = q_pos + 1'b1;
                t_pos = t_pos + 1'b1;
            end
            if (c.q_gap) begin
                if (!last_qg) q_runs = bump(q_runs);
                q_bases = bump(q_bases);
            end
            if (c.t_gap) begin
                if (!last_tg) t_runs = bump(t_runs);
                t_bases = bump(t_bases);
            end
            last_qg = c.q_gap;
            last_tg = c.t_gap;
        end
        if (c.last) begin
            res[n].final_block = 1'b1;
            if (aln_error) begin
                res[n].leading_gap_error = 1'b1;
            end else begin
                res[n].block_size          = clip_size(q_pos, blk_q0);
                res[n].block_query_start   = blk_q0;
                res[n].block_target_start  = blk_t0;
                res[n].query_insert_runs   = q_runs;
                res[n].query_insert_bases  = q_bases;
                res[n].target_insert_runs  = t_runs;
                res[n].target_insert_bases = t_bases;
                res[n].total_blocks        = TOT_W'(1) + TOT_W'(q_runs) + TOT_W'(t_runs);
            end
            n++;
        end
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_column(input column_t c, input logic typed, input t_result want);
        t_result r0;
        t_result r1;
        int      n;
        int      idle;
        idle = (in_calm || burst_left > 0) ? 0 : $urandom_range(0, 9);
        if (burst_left > 0) burst_left--;
        if (idle > 0) begin
            i_in_valid = 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_first_column  = c.first;
        i_last_column   = c.last;
        i_query_start   = c.q_start;
        i_target_start  = c.t_start;
        i_query_is_gap  = c.q_gap;
        i_target_is_gap = c.t_gap;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        n = split_column(c, r0, r1);
        if (typed) begin
            block_queue.push_back(want);
        end else begin
            if (n > 0) block_queue.push_back(r0);
            if (n > 1) block_queue.push_back(r1);
        end
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic take_result();
        t_result want;
        if (block_queue.size() == 0) begin
            $error("block transfer with nothing expected: size %0d, query start %0d",
                   o_block_size, o_block_query_start);
            fail_count++;
        end else begin
            want = block_queue.pop_front();
            check_field("block_size", want.block_size, o_block_size);
            check_field("block_query_start", want.block_query_start, o_block_query_start);
            check_field("block_target_start", want.block_target_start,
                        o_block_target_start);
            check_field("final_block", want.final_block, o_final_block);
            check_field("query_insert_runs", want.query_insert_runs, o_query_insert_runs);
            check_field("query_insert_bases", want.query_insert_bases,
                        o_query_insert_bases);
            check_field("target_insert_runs", want.target_insert_runs,
                        o_target_insert_runs);
            check_field("target_insert_bases", want.target_insert_bases,
                        o_target_insert_bases);
            check_field("total_blocks", want.total_blocks, o_total_blocks);
            check_field("leading_gap_error", want.leading_gap_error, o_leading_gap_error);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: a random pause before each transfer, or the long hold-off.
    initial begin
        int pause;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                pause        = HOLD_CYCLES;
            end else begin
                pause = out_calm ? 0 : $urandom_range(0, 9);
            end
            if (pause > 0) begin
                i_out_ready = 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            take_result();
            @(negedge i_clk);
        end
    end

    initial begin
        column_t c;
        int      len;
        int      k;
        int      mix;
        int      items_sent;
        bit      lead_gap;
        bit      drop_last;
        bit      hold_done;
        items_sent      = 0;
        hold_done       = 1'b0;
        gap_open        = 1'b0;
        blk_q0          = '0;
        blk_t0          = '0;
        q_pos           = '0;
        t_pos           = '0;
        last_qg         = 1'b0;
        last_tg         = 1'b0;
        q_runs          = '0;
        q_bases         = '0;
        t_runs          = '0;
        t_bases         = '0;
        aln_error       = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_first_column  = 1'b0;
        i_last_column   = 1'b0;
        i_query_start   = '0;
        i_target_start  = '0;
        i_query_is_gap  = 1'b0;
        i_target_is_gap = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_column(DIRECTED[i].col, DIRECTED[i].typed, DIRECTED[i].want);

        while (items_sent < RANDOM_COLUMNS) begin
            len       = $urandom_range(1, 12);
            lead_gap  = ($urandom_range(0, 9) == 0);
            drop_last = ($urandom_range(0, 9) == 0);
            in_calm   = ($urandom_range(0, 4) == 0);
            out_calm  = ($urandom_range(0, 4) == 0);
            if (!hold_done && items_sent >= 150) begin
                // The receiver stalls while columns keep coming back to back.
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                burst_left   = BURST_COLUMNS;
            end
            for (k = 0; k < len; k++) begin
                c.first   = (k == 0);
                c.last    = (k == len - 1) && !drop_last;
                c.q_start = ($urandom_range(0, 3) == 0) ?
                            32'hFFFF_FFF8 + $urandom_range(0, 15) : $urandom;
                c.t_start = ($urandom_range(0, 3) == 0) ?
                            32'hFFFF_FFF8 + $urandom_range(0, 15) : $urandom;
                mix = $urandom_range(0, 9);
                if (k == 0) mix = lead_gap ? $urandom_range(5, 9) : 0;
                c.q_gap = (mix == 5 || mix == 6 || mix == 9);
                c.t_gap = (mix == 7 || mix == 8 || mix == 9);
                send_column(c, 1'b0, NO_BLOCK);
                items_sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                // Stray column that continues the previous alignment.
                c.first = 1'b0;
                c.last  = 1'($urandom_range(0, 1));
                c.q_gap = 1'($urandom_range(0, 1));
                c.t_gap = 1'($urandom_range(0, 1));
                send_column(c, 1'b0, NO_BLOCK);
                items_sent++;
            end
        end
        i_in_valid = 1'b0;

        while (block_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (block_queue.size() != 0) begin
            $error("%0d expected blocks never arrived", block_queue.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
